// File: rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CPC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent on the following clock edge
`define CPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/cpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MIN_VERTICES = 3;
  localparam int COORD_BITS   = 16;
  localparam int SLOT_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
  localparam int VCOUNT_BITS  = 7;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  // local point, world point minus offset
  localparam int PT_BITS  = COORD_BITS + 1;
  localparam int SCL_BITS = CNT_BITS + 1;
  // coordinates scaled by vertex count, also holds the vertex sum
  localparam int TW_BITS  = PT_BITS + CNT_BITS;
  localparam int DW_BITS  = TW_BITS + 1;
  localparam int PR_BITS  = 2 * DW_BITS;
  localparam int AW_BITS  = PR_BITS + 3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_VCOUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFX   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFY   = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PT_BITS-1:0]    pcoord_t;
  typedef logic signed [SCL_BITS-1:0]   scl_t;
  typedef logic signed [TW_BITS-1:0]    tcoord_t;
  typedef logic signed [DW_BITS-1:0]    dcoord_t;
  typedef logic signed [PR_BITS-1:0]    prod_t;
  typedef logic signed [AW_BITS-1:0]    acc_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [SLOT_BITS-1:0]         slot_t;
  typedef logic [VCOUNT_BITS-1:0]       vcount_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vtx_t;

  typedef struct packed {
    tcoord_t x;
    tcoord_t y;
  } tpt_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } tri_stat_t;

endpackage

`default_nettype wire

// File: rtl/cpc_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface cpc_in_if;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  cpc_pkg::slot_t        vertex_slot;
  cpc_pkg::coord_t       coord_x;
  cpc_pkg::coord_t       coord_y;
  modport source (output valid, operation, vertex_slot, coord_x, coord_y, input ready);
  modport sink (input valid, operation, vertex_slot, coord_x, coord_y, output ready);
endinterface

interface cpc_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

interface cpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cpc_pkg::CFG_IDX_BITS-1:0]    index;
  logic [cpc_pkg::CFG_DATA_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/cpc_vertex_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module cpc_vertex_mem (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire cpc_pkg::slot_t waddr,
  input  wire cpc_pkg::vtx_t  wdata,
  input  wire logic           re,
  input  wire cpc_pkg::slot_t raddr,
  output cpc_pkg::vtx_t       rdata
);

  cpc_pkg::vtx_t mem [cpc_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cpc_tri_test.sv
`timescale 1ns / 1ps
`default_nettype none

// exact barycentric triangle test, one triangle in flight
module cpc_tri_test (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire cpc_pkg::tpt_t pa,
  input  wire cpc_pkg::tpt_t pb,
  input  wire cpc_pkg::tpt_t pc,
  input  wire cpc_pkg::tpt_t pp,
  output cpc_pkg::tri_stat_t stat
);

  function automatic cpc_pkg::prod_t mul(cpc_pkg::dcoord_t a, cpc_pkg::dcoord_t b);
    mul = a * b;
  endfunction

  logic [5:0] stg_r;
  cpc_pkg::dcoord_t v0x_r, v0y_r, v1x_r, v1y_r, v2x_r, v2y_r;
  cpc_pkg::prod_t   ma0_r, ma1_r, ma2_r, mb0_r, mb1_r, mb2_r;
  cpc_pkg::acc_t    d_r, s1_r, s2_r;
  cpc_pkg::acc_t    dn_r, s1n_r, s2n_r;
  logic             dz_r;
  logic             hit_r;
  cpc_pkg::acc_t    tot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= {stg_r[4:0], start};
    end
  end

  assign tot = s1n_r + s2n_r - dn_r;

  always_ff @(posedge clk) begin
    if (start) begin
      v0x_r <= cpc_pkg::dcoord_t'(pc.x) - cpc_pkg::dcoord_t'(pa.x);
      v0y_r <= cpc_pkg::dcoord_t'(pc.y) - cpc_pkg::dcoord_t'(pa.y);
      v1x_r <= cpc_pkg::dcoord_t'(pb.x) - cpc_pkg::dcoord_t'(pa.x);
      v1y_r <= cpc_pkg::dcoord_t'(pb.y) - cpc_pkg::dcoord_t'(pa.y);
      v2x_r <= cpc_pkg::dcoord_t'(pp.x) - cpc_pkg::dcoord_t'(pa.x);
      v2y_r <= cpc_pkg::dcoord_t'(pp.y) - cpc_pkg::dcoord_t'(pa.y);
    end
    if (stg_r[0]) begin
      ma0_r <= mul(v0x_r, v1y_r);
      ma1_r <= mul(v2x_r, v1y_r);
      ma2_r <= mul(v0x_r, v2y_r);
    end
    if (stg_r[1]) begin
      mb0_r <= mul(v0y_r, v1x_r);
      mb1_r <= mul(v2y_r, v1x_r);
      mb2_r <= mul(v0y_r, v2x_r);
    end
    if (stg_r[2]) begin
      d_r  <= cpc_pkg::acc_t'(ma0_r) - cpc_pkg::acc_t'(mb0_r);
      s1_r <= cpc_pkg::acc_t'(ma1_r) - cpc_pkg::acc_t'(mb1_r);
      s2_r <= cpc_pkg::acc_t'(ma2_r) - cpc_pkg::acc_t'(mb2_r);
    end
    // fold a negative denominator into positive form
    if (stg_r[3]) begin
      dz_r  <= (d_r == '0);
      dn_r  <= d_r[cpc_pkg::AW_BITS-1] ? -d_r : d_r;
      s1n_r <= d_r[cpc_pkg::AW_BITS-1] ? -s1_r : s1_r;
      s2n_r <= d_r[cpc_pkg::AW_BITS-1] ? -s2_r : s2_r;
    end
    if (stg_r[4]) begin
      hit_r <= !dz_r && !s1n_r[cpc_pkg::AW_BITS-1] && !s2n_r[cpc_pkg::AW_BITS-1]
               && tot[cpc_pkg::AW_BITS-1];
    end
  end

  assign stat.busy = |stg_r[4:0];
  assign stat.done = stg_r[5];
  assign stat.hit  = hit_r;

endmodule

`default_nettype wire

// File: rtl/convex_polygon_point_containment.sv
`timescale 1ns / 1ps
`default_nettype none

// Point in convex polygon. A load transaction (operation 0) writes one vertex
// into its slot. A query transaction (operation 1) gives one result: the
// point, minus the polygon offset, is tested against the single triangle of
// vertices 0..2 when the count in use is three, else against the fan of
// triangles from the vertex sum to each edge with everything scaled by the
// count. The count in use is vertex_count clamped to 3..64. Vertices, the
// offset and the count are all exact integers and no division is done.
// A larger query first sums the vertices and reads vertex 0, then tests one
// fan triangle per edge (the closing edge wraps back to vertex 0) and hands
// off the result; the walk stops early when a triangle already holds the
// point. Query time is set by the single read port of the vertex memory and
// the shared triangle unit, which handles one triangle at a time. Loads are
// taken while a finished result still waits on the output. Reading a slot
// never loaded gives an undefined answer. Configuration writes are always
// taken.
module convex_polygon_point_containment (
  input  wire logic clk,
  input  wire logic rst_n,
  cpc_in_if.sink    in_ch,
  cpc_out_if.source out_ch,
  cpc_cfg_if.sink   cfg_ch
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_PREP      = 4'd1;
  localparam logic [3:0] ST_SUM       = 4'd2;
  localparam logic [3:0] ST_FIRST_RD  = 4'd3;
  localparam logic [3:0] ST_FIRST_LAT = 4'd4;
  localparam logic [3:0] ST_NEXT_RD   = 4'd5;
  localparam logic [3:0] ST_NEXT_LAT  = 4'd6;
  localparam logic [3:0] ST_TRI_GO    = 4'd7;
  localparam logic [3:0] ST_TRI_WAIT  = 4'd8;
  localparam logic [3:0] ST_DONE      = 4'd9;

  logic [3:0] state_r, state_nxt;

  // configuration registers
  cpc_pkg::vcount_t vcount_r;
  cpc_pkg::coord_t  offx_r, offy_r;

  // query context
  cpc_pkg::cnt_t    n_r, idx_r, n_clamp;
  logic             tri3_r, vld_r, res_r;
  cpc_pkg::scl_t    scale_r;
  cpc_pkg::pcoord_t px_r, py_r;
  cpc_pkg::tpt_t    pp_r, sum_r, first_r, prev_r, cur_r, rd_scl, tri_a;

  // result register
  logic out_valid_r, inside_r;

  // memory ports
  logic             mem_we, mem_re;
  cpc_pkg::slot_t   mem_raddr;
  cpc_pkg::vtx_t    mem_wdata, mem_rdata;

  logic in_fire, out_fire, cfg_fire, done_go, tri_start;
  cpc_pkg::tri_stat_t tri_stat;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  // loads and queries are only taken between queries
  assign in_ch.ready   = (state_r == ST_IDLE);
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.inside_res = inside_r;

  // clamp the count in use to the supported range
  always_comb begin
    if (vcount_r < cpc_pkg::VCOUNT_BITS'(cpc_pkg::MIN_VERTICES)) begin
      n_clamp = cpc_pkg::cnt_t'(cpc_pkg::MIN_VERTICES);
    end else if (vcount_r > cpc_pkg::VCOUNT_BITS'(cpc_pkg::MAX_VERTICES)) begin
      n_clamp = cpc_pkg::cnt_t'(cpc_pkg::MAX_VERTICES);
    end else begin
      n_clamp = cpc_pkg::cnt_t'(vcount_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= cpc_pkg::vcount_t'(cpc_pkg::MIN_VERTICES);
      offx_r   <= '0;
      offy_r   <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        cpc_pkg::REG_VCOUNT: vcount_r <= cfg_ch.data[cpc_pkg::VCOUNT_BITS-1:0];
        cpc_pkg::REG_OFFX:   offx_r   <= cpc_pkg::coord_t'(cfg_ch.data);
        cpc_pkg::REG_OFFY:   offy_r   <= cpc_pkg::coord_t'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // vertex store, written by loads and read while a query runs
  assign mem_we    = in_fire && (in_ch.operation == cpc_pkg::OP_LOAD);
  assign mem_wdata = '{x: in_ch.coord_x, y: in_ch.coord_y};

  cpc_vertex_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_ch.vertex_slot),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // vertex read back, scaled by the count (by one for a lone triangle)
  assign rd_scl.x = cpc_pkg::tcoord_t'(mem_rdata.x) * cpc_pkg::tcoord_t'(scale_r);
  assign rd_scl.y = cpc_pkg::tcoord_t'(mem_rdata.y) * cpc_pkg::tcoord_t'(scale_r);

  // lone triangle is anchored at vertex 0, the fan at the vertex sum
  assign tri_a     = tri3_r ? first_r : sum_r;
  assign tri_start = (state_r == ST_TRI_GO);

  cpc_tri_test u_tri (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tri_start),
    .pa    (tri_a),
    .pb    (prev_r),
    .pc    (cur_r),
    .pp    (pp_r),
    .stat  (tri_stat)
  );

  assign done_go = !out_valid_r || out_ch.ready;

  // sequencer and memory read control
  always_comb begin
    state_nxt = state_r;
    mem_re    = 1'b0;
    mem_raddr = idx_r[cpc_pkg::SLOT_BITS-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.operation == cpc_pkg::OP_QUERY)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = tri3_r ? ST_FIRST_RD : ST_SUM;
      ST_SUM: begin
        mem_re = (idx_r != n_r);
        if ((idx_r == n_r) && !vld_r) begin
          state_nxt = ST_FIRST_RD;
        end
      end
      ST_FIRST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = ST_FIRST_LAT;
      end
      ST_FIRST_LAT: state_nxt = ST_NEXT_RD;
      ST_NEXT_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_NEXT_LAT;
      end
      ST_NEXT_LAT: begin
        if (tri3_r && (idx_r == cpc_pkg::cnt_t'(1))) begin
          state_nxt = ST_NEXT_RD;
        end else begin
          state_nxt = ST_TRI_GO;
        end
      end
      ST_TRI_GO: state_nxt = ST_TRI_WAIT;
      ST_TRI_WAIT: begin
        if (tri_stat.done) begin
          if (tri_stat.hit || tri3_r || (idx_r == n_r)) begin
            state_nxt = ST_DONE;
          end else if (cpc_pkg::cnt_t'(idx_r + 1'b1) == n_r) begin
            state_nxt = ST_TRI_GO;
          end else begin
            state_nxt = ST_NEXT_RD;
          end
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= (state_r == ST_SUM) && (idx_r != n_r);
      if ((state_r == ST_DONE) && done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          px_r    <= cpc_pkg::pcoord_t'(in_ch.coord_x) - cpc_pkg::pcoord_t'(offx_r);
          py_r    <= cpc_pkg::pcoord_t'(in_ch.coord_y) - cpc_pkg::pcoord_t'(offy_r);
          n_r     <= n_clamp;
          tri3_r  <= (n_clamp == cpc_pkg::cnt_t'(cpc_pkg::MIN_VERTICES));
          scale_r <= (n_clamp == cpc_pkg::cnt_t'(cpc_pkg::MIN_VERTICES))
                     ? cpc_pkg::scl_t'(1) : cpc_pkg::scl_t'(n_clamp);
          idx_r   <= '0;
          sum_r   <= '0;
        end
      end
      ST_PREP: begin
        pp_r.x <= cpc_pkg::tcoord_t'(px_r) * cpc_pkg::tcoord_t'(scale_r);
        pp_r.y <= cpc_pkg::tcoord_t'(py_r) * cpc_pkg::tcoord_t'(scale_r);
      end
      ST_SUM: begin
        // reads issue back to back, data lands in the following cycle
        if (idx_r != n_r) begin
          idx_r <= cpc_pkg::cnt_t'(idx_r + 1'b1);
        end
        if (vld_r) begin
          sum_r.x <= sum_r.x + cpc_pkg::tcoord_t'(mem_rdata.x);
          sum_r.y <= sum_r.y + cpc_pkg::tcoord_t'(mem_rdata.y);
        end
      end
      ST_FIRST_LAT: begin
        first_r <= rd_scl;
        prev_r  <= rd_scl;
        idx_r   <= cpc_pkg::cnt_t'(1);
      end
      ST_NEXT_LAT: begin
        if (tri3_r && (idx_r == cpc_pkg::cnt_t'(1))) begin
          prev_r <= rd_scl;
          idx_r  <= cpc_pkg::cnt_t'(2);
        end else begin
          cur_r <= rd_scl;
        end
      end
      ST_TRI_WAIT: begin
        if (tri_stat.done) begin
          res_r <= tri_stat.hit;
          if (!tri_stat.hit && !tri3_r && (idx_r != n_r)) begin
            prev_r <= cur_r;
            idx_r  <= cpc_pkg::cnt_t'(idx_r + 1'b1);
            // closing edge wraps back to vertex 0
            if (cpc_pkg::cnt_t'(idx_r + 1'b1) == n_r) begin
              cur_r <= first_r;
            end
          end
        end
      end
      ST_DONE: begin
        if (done_go) begin
          inside_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  `include "assert_macros.svh"

  // a load never shares a cycle with a query read of the store
  `CPC_ASSERT_ALWAYS(a_no_rw_overlap, !(mem_we && mem_re))
  // the triangle unit is only started when empty
  `CPC_ASSERT_ALWAYS(a_tri_idle_start, !(tri_start && tri_stat.busy))
  // the vertex walk never runs past the count in use
  `CPC_ASSERT_ALWAYS(a_idx_bound, (state_r == ST_IDLE) || (idx_r <= n_r))
  // an accepted query always starts the sequencer
  `CPC_ASSERT_NEXT(a_query_starts, in_fire && (in_ch.operation == cpc_pkg::OP_QUERY),
                   state_r == ST_PREP)

endmodule

`default_nettype wire

// File: tb/convex_polygon_point_containment_tb.sv
`timescale 1ns / 1ps

module convex_polygon_point_containment_tb;

  logic clk;
  logic rst_n;

  cpc_in_if  in_ch ();
  cpc_out_if out_ch ();
  cpc_cfg_if cfg_ch ();

  convex_polygon_point_containment dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // one pending input transaction
  typedef struct {
    logic            operation;
    cpc_pkg::slot_t  slot;
    cpc_pkg::coord_t x;
    cpc_pkg::coord_t y;
  } cmd_t;

  localparam int CYCLE_LIMIT = 2000000;

  cmd_t pending_cmds[$];
  bit   expected_inside[$];

  // predictor copy of the polygon
  longint poly_x[cpc_pkg::MAX_VERTICES];
  longint poly_y[cpc_pkg::MAX_VERTICES];
  int     cnt_reg;
  longint offx_reg;
  longint offy_reg;

  int     mismatches;
  int     queries_seen;
  int     inside_seen;
  int     loads_sent;
  longint cycle_count;
  int     hold_cycles;
  bit     hold_done;
  int     burst_left;
  int     gap_left;
  int     stall_phase;

  // 2d cross products stay below 2^100, so 128-bit signed is exact
  function automatic logic signed [127:0] crs(longint ax, longint ay, longint bx, longint by);
    logic signed [127:0] a1, a2, b1, b2;
    a1 = ax; a2 = ay; b1 = bx; b2 = by;
    return a1 * b2 - a2 * b1;
  endfunction

  function automatic bit in_tri(longint px, longint py, longint ax, longint ay,
                                longint bx, longint by, longint cx, longint cy);
    logic signed [127:0] d, s1, s2;
    d  = crs(cx - ax, cy - ay, bx - ax, by - ay);
    s1 = crs(px - ax, py - ay, bx - ax, by - ay);
    s2 = crs(cx - ax, cy - ay, px - ax, py - ay);
    if (d == 0) return 0;
    if (d < 0) begin
      d = -d; s1 = -s1; s2 = -s2;
    end
    if (s1 < 0 || s2 < 0) return 0;
    return (s1 + s2) < d;
  endfunction

  function automatic bit point_inside(cpc_pkg::coord_t wx, cpc_pkg::coord_t wy);
    longint px, py, sx, sy, n;
    int     nv, j;
    nv = cnt_reg < cpc_pkg::MIN_VERTICES ? cpc_pkg::MIN_VERTICES :
         (cnt_reg > cpc_pkg::MAX_VERTICES ? cpc_pkg::MAX_VERTICES : cnt_reg);
    px = longint'(wx) - offx_reg;
    py = longint'(wy) - offy_reg;
    if (nv == 3)
      return in_tri(px, py, poly_x[0], poly_y[0], poly_x[1], poly_y[1],
                    poly_x[2], poly_y[2]);
    sx = 0; sy = 0; n = nv;
    for (int i = 0; i < nv; i++) begin
      sx += poly_x[i]; sy += poly_y[i];
    end
    for (int i = 0; i < nv; i++) begin
      j = (i + 1 == nv) ? 0 : i + 1;
      if (in_tri(px * n, py * n, sx, sy, poly_x[i] * n, poly_y[i] * n,
                 poly_x[j] * n, poly_y[j] * n))
        return 1;
    end
    return 0;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: bursts of offered transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        // update the model at acceptance
        if (in_ch.operation == cpc_pkg::OP_LOAD) begin
          poly_x[in_ch.vertex_slot] = in_ch.coord_x;
          poly_y[in_ch.vertex_slot] = in_ch.coord_y;
          loads_sent++;
        end else begin
          expected_inside = {expected_inside, point_inside(in_ch.coord_x, in_ch.coord_y)};
        end
        void'(pending_cmds.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered transaction
      end else if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_ch.valid <= 0;
      end else if (pending_cmds.size() != 0) begin
        in_ch.valid       <= 1;
        in_ch.operation   <= pending_cmds[0].operation;
        in_ch.vertex_slot <= pending_cmds[0].slot;
        in_ch.coord_x     <= pending_cmds[0].x;
        in_ch.coord_y     <= pending_cmds[0].y;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // long hold-off on the result side, counted here; the first one is certain
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_done   <= 0;
    end else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    else if (!hold_done && out_ch.valid) begin
      hold_cycles <= 1500;
      hold_done   <= 1;
    end
    else if ($urandom_range(0, 2999) == 0) hold_cycles <= $urandom_range(300, 1200);
  end

  // receiver stall pattern: phases of always ready, random and mostly stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      stall_phase  <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_phase <= $urandom_range(0, 2);
      if (hold_cycles > 0) out_ch.ready <= 0;
      else case (stall_phase)
        0: out_ch.ready <= 1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      queries_seen++;
      if (expected_inside.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result inside_res=%0b", out_ch.inside_res);
      end else begin
        if (out_ch.inside_res !== expected_inside[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("inside_res mismatch: expected %0b got %0b",
                     expected_inside[0], out_ch.inside_res);
        end
        if (out_ch.inside_res === 1'b1) inside_seen++;
        void'(expected_inside.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_inside.size() != 0)
      @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(logic [cpc_pkg::CFG_IDX_BITS-1:0] idx, int value);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[cpc_pkg::CFG_DATA_BITS-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    if (idx == cpc_pkg::REG_VCOUNT) cnt_reg = value & 7'h7f;
    else if (idx == cpc_pkg::REG_OFFX) offx_reg = longint'(cpc_pkg::coord_t'(value[15:0]));
    else if (idx == cpc_pkg::REG_OFFY) offy_reg = longint'(cpc_pkg::coord_t'(value[15:0]));
  endtask

  function automatic void push_cmd(logic op, int slot, int x, int y);
    cmd_t c;
    c.operation = op;
    c.slot      = slot[cpc_pkg::SLOT_BITS-1:0];
    c.x         = x[15:0];
    c.y         = y[15:0];
    pending_cmds = {pending_cmds, c};
  endfunction

  // regular polygon around the origin with the given radius
  function automatic void load_polygon(int nv, int radius);
    real ang;
    for (int i = 0; i < nv; i++) begin
      ang = 6.283185307 * i / nv;
      push_cmd(cpc_pkg::OP_LOAD, i, $rtoi(radius * $cos(ang)), $rtoi(radius * $sin(ang)));
    end
  endfunction

  initial begin
    int nv, rad, qx, qy, sel;
    rst_n = 0;
    in_ch.valid = 0; in_ch.operation = 0; in_ch.vertex_slot = 0;
    in_ch.coord_x = 0; in_ch.coord_y = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
    cnt_reg = 3; offx_reg = 0; offy_reg = 0;
    mismatches = 0; queries_seen = 0; inside_seen = 0; loads_sent = 0;
    cycle_count = 0;
    for (int i = 0; i < cpc_pkg::MAX_VERTICES; i++) begin
      poly_x[i] = 0; poly_y[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fill every slot so no unwritten read is possible
    for (int i = 0; i < cpc_pkg::MAX_VERTICES; i++) push_cmd(cpc_pkg::OP_LOAD, i, 0, 0);
    // extreme triangle, queries at a vertex, near the origin and at the far corner of the range
    push_cmd(cpc_pkg::OP_LOAD, 0, -32768, -32768);
    push_cmd(cpc_pkg::OP_LOAD, 1, 32767, -32768);
    push_cmd(cpc_pkg::OP_LOAD, 2, -32768, 32767);
    push_cmd(cpc_pkg::OP_QUERY, 0, -32768, -32768);
    push_cmd(cpc_pkg::OP_QUERY, 63, 0, 0);
    push_cmd(cpc_pkg::OP_QUERY, 5, 32767, 32767);
    push_cmd(cpc_pkg::OP_QUERY, 0, -1, -1);
    // degenerate triangle
    push_cmd(cpc_pkg::OP_LOAD, 0, 0, 0);
    push_cmd(cpc_pkg::OP_LOAD, 1, 100, 100);
    push_cmd(cpc_pkg::OP_LOAD, 2, 200, 200);
    push_cmd(cpc_pkg::OP_QUERY, 0, 100, 100);
    push_cmd(cpc_pkg::OP_QUERY, 0, 50, 51);
    wait_drained();

    // count written below the range clamps to three, then large offsets
    write_reg(cpc_pkg::REG_VCOUNT, 0);
    write_reg(cpc_pkg::REG_OFFX, 32767);
    write_reg(cpc_pkg::REG_OFFY, -32768);
    load_polygon(3, 30000);
    push_cmd(cpc_pkg::OP_QUERY, 0, 32767, -32768);
    push_cmd(cpc_pkg::OP_QUERY, 0, -32768, 32767);
    wait_drained();
    // count above the range clamps to the maximum
    write_reg(cpc_pkg::REG_VCOUNT, 127);
    write_reg(cpc_pkg::REG_OFFX, -32768);
    write_reg(cpc_pkg::REG_OFFY, 32767);
    load_polygon(64, 32000);
    push_cmd(cpc_pkg::OP_QUERY, 0, -32768, 32767);
    push_cmd(cpc_pkg::OP_QUERY, 0, 32767, -32768);
    push_cmd(cpc_pkg::OP_QUERY, 0, -1000, 32000);
    wait_drained();

    // random phases: a polygon, sometimes with stray loads, then queries around it or anywhere, with random slots
    for (int ph = 0; ph < 16; ph++) begin
      sel = $urandom_range(0, 3);
      nv = (sel == 0) ? 3 : (sel == 3 ? $urandom_range(3, 64) : $urandom_range(4, 10));
      if (ph == 15) nv = 64;
      write_reg(cpc_pkg::REG_VCOUNT,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : nv);
      write_reg(cpc_pkg::REG_OFFX,
                ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                            : int'($urandom_range(0, 2000)) - 1000);
      write_reg(cpc_pkg::REG_OFFY,
                ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                            : int'($urandom_range(0, 2000)) - 1000);
      rad = $urandom_range(0, 3) == 0 ? 32000 : $urandom_range(10, 3000);
      load_polygon(nv, rad);
      if ($urandom_range(0, 2) == 0)
        for (int k = 0; k < 3; k++)
          push_cmd(cpc_pkg::OP_LOAD, $urandom_range(0, 63),
                   int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768);
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          qx = int'($urandom_range(0, 65535)) - 32768;
          qy = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          qx = int'(offx_reg) + int'($urandom_range(0, 2 * rad + 2)) - rad - 1;
          qy = int'(offy_reg) + int'($urandom_range(0, 2 * rad + 2)) - rad - 1;
        end
        push_cmd(cpc_pkg::OP_QUERY, $urandom_range(0, 63), qx, qy);
      end
      wait_drained();
    end

    $display("covered %0d vertex loads and %0d queries, %0d inside",
             loads_sent, queries_seen, inside_seen);
    $display("vertex counts 3..64 with clamping, offsets at both extremes");
    if (mismatches == 0 && expected_inside.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/cpc_pkg.sv
rtl/cpc_channels.sv
rtl/cpc_vertex_mem.sv
rtl/cpc_tri_test.sv
rtl/convex_polygon_point_containment.sv
tb/convex_polygon_point_containment_tb.sv
